@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, c, r, ante, cons) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, c, r, ante, cons) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hdl/btk_pkg.sv @@
`default_nettype none

package btk_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int NODE_W = 16;
    localparam int SLOT_W = NODE_W + 1;
    localparam int WALK_W = 9;
    localparam int REM_W  = 4;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_SET    = 2'd2;

    localparam logic [SLOT_W-1:0] PAIR_STEP = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] NODE_MAX  = SLOT_W'(65534);
    localparam logic [REM_W-1:0]  BITS_BYTE = REM_W'(8);
    localparam logic [REM_W-1:0]  BITS_TERM = REM_W'(9);

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_LOOKUP,
        OP_SET,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } back_state_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [7:0]        key_byte;
        logic              key_end;
        logic              first_of_key;
        logic [NODE_W-1:0] start_node;
    } item_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              found;
        logic              full_res;
    } result_t;

    typedef struct packed {
        op_t               op;
        logic [WALK_W-1:0] walk;
        logic [REM_W-1:0]  nbits;
        logic              first;
        logic [NODE_W-1:0] start_node;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic clearing;
        logic idle;
    } back_stat_t;

endpackage

`default_nettype wire

@@ hdl/btk_front.sv @@
`default_nettype none

module btk_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire btk_pkg::item_t     item,
    input  wire btk_pkg::q_stat_t   qstat,
    input  wire btk_pkg::back_stat_t bstat,
    output logic                    busy,
    output logic                    push,
    output btk_pkg::job_t           push_job
);
    import btk_pkg::*;

    logic valid_reg;
    logic valid_next;
    job_t job_reg;
    job_t job_next;
    job_t job_cls;
    logic accept;

    always_comb
    begin
        job_cls.walk       = {item.key_byte, 1'b0};
        job_cls.nbits      = item.key_end ? BITS_TERM : BITS_BYTE;
        job_cls.first      = item.first_of_key;
        job_cls.start_node = item.start_node;
        unique case (item.cmd)
            CMD_INSERT: job_cls.op = OP_INSERT;
            CMD_LOOKUP: job_cls.op = OP_LOOKUP;
            CMD_SET:    job_cls.op = OP_SET;
            default:    job_cls.op = OP_NOP;
        endcase
    end

    assign busy     = bstat.clearing | (valid_reg & qstat.full);
    assign accept   = start & ~busy;
    assign push     = valid_reg & ~qstat.full;
    assign push_job = job_reg;

    always_comb
    begin
        valid_next = accept | (valid_reg & ~push);
        job_next   = accept ? job_cls : job_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

`default_nettype wire

@@ hdl/btk_queue.sv @@
`default_nettype none

module btk_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire btk_pkg::job_t    push_job,
    input  wire logic             pop,
    output btk_pkg::job_t         head_job,
    output btk_pkg::q_stat_t      qstat
);
    import btk_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push & ~qstat.full;
    assign do_pop      = pop & ~qstat.empty;
    assign head_job    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

@@ hdl/btk_back.sv @@
`default_nettype none

module btk_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire btk_pkg::job_t     head_job,
    input  wire btk_pkg::q_stat_t  qstat,
    output logic                   pop,
    output btk_pkg::back_stat_t    bstat,
    output logic                   done,
    output btk_pkg::result_t       result
);
    import btk_pkg::*;

    logic [NODE_W-1:0] mem [STORE_DEPTH];
    logic [NODE_W-1:0] rd_data_reg;
    logic              mem_rd;
    logic              mem_wr;
    logic [STORE_AW-1:0] mem_addr;
    logic [NODE_W-1:0] mem_wdata;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [STORE_AW-1:0] clr_addr_reg;
    logic [STORE_AW-1:0] clr_addr_next;
    op_t               op_reg;
    op_t               op_next;
    logic [WALK_W-1:0] walk_reg;
    logic [WALK_W-1:0] walk_next;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [NODE_W-1:0] icur_reg;
    logic [NODE_W-1:0] icur_next;
    logic [NODE_W-1:0] lcur_reg;
    logic [NODE_W-1:0] lcur_next;
    logic              missed_reg;
    logic              missed_next;
    logic [NODE_W-1:0] free_reg;
    logic [NODE_W-1:0] free_next;
    logic              full_reg;
    logic              full_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              done_reg;
    logic              done_next;
    result_t           result_reg;
    result_t           result_next;

    logic [NODE_W-1:0] cur;
    logic [SLOT_W-1:0] slot;
    logic              slot_ok;
    logic [SLOT_W-1:0] fresh;
    logic              no_room;
    logic              last_bit;

    assign cur      = (op_reg == OP_INSERT) ? icur_reg : lcur_reg;
    assign slot     = {1'b0, cur} + SLOT_W'(walk_reg[WALK_W-1]);
    assign slot_ok  = (32'(slot) < 32'(STORE_DEPTH));
    assign fresh    = {1'b0, free_reg} + PAIR_STEP;
    assign no_room  = (fresh > NODE_MAX) || (32'(fresh) + 32'd1 >= 32'(STORE_DEPTH));
    assign last_bit = (rem_reg == REM_W'(1));

    assign bstat.clearing = (state_reg == S_CLEAR);
    assign bstat.idle     = (state_reg == S_IDLE);
    assign done           = done_reg;
    assign result         = result_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        op_next       = op_reg;
        walk_next     = walk_reg;
        rem_next      = rem_reg;
        icur_next     = icur_reg;
        lcur_next     = lcur_reg;
        missed_next   = missed_reg;
        free_next     = free_reg;
        full_next     = full_reg;
        slot_next     = slot_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        pop           = 1'b0;
        mem_rd        = 1'b0;
        mem_wr        = 1'b0;
        mem_addr      = STORE_AW'(slot);
        mem_wdata     = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_wr        = 1'b1;
                mem_addr      = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == STORE_AW'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop       = 1'b1;
                    op_next   = head_job.op;
                    walk_next = head_job.walk;
                    rem_next  = head_job.nbits;
                    full_next = 1'b0;
                    unique case (head_job.op)
                        OP_INSERT:
                        begin
                            state_next = S_READ;
                        end
                        OP_LOOKUP:
                        begin
                            if (head_job.first)
                            begin
                                lcur_next   = head_job.start_node;
                                missed_next = 1'b0;
                            end
                            state_next = S_READ;
                        end
                        OP_SET:
                        begin
                            icur_next  = head_job.start_node;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                slot_next = slot;
                if ((op_reg == OP_LOOKUP && missed_reg) || !slot_ok)
                begin
                    if (!slot_ok && op_reg == OP_INSERT)
                    begin
                        full_next = 1'b1;
                    end
                    else if (!slot_ok)
                    begin
                        missed_next = 1'b1;
                        lcur_next   = '0;
                    end
                    if (last_bit)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rem_next  = rem_reg - 1'b1;
                        walk_next = {walk_reg[WALK_W-2:0], 1'b0};
                    end
                end
                else
                begin
                    mem_rd     = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                mem_addr = STORE_AW'(slot_reg);
                if (op_reg == OP_INSERT)
                begin
                    if (rd_data_reg != '0)
                    begin
                        icur_next = rd_data_reg;
                    end
                    else if (no_room)
                    begin
                        full_next = 1'b1;
                    end
                    else
                    begin
                        mem_wr    = 1'b1;
                        mem_wdata = NODE_W'(fresh);
                        free_next = NODE_W'(fresh);
                        icur_next = NODE_W'(fresh);
                    end
                end
                else
                begin
                    if (rd_data_reg == '0)
                    begin
                        missed_next = 1'b1;
                        lcur_next   = '0;
                    end
                    else
                    begin
                        lcur_next = rd_data_reg;
                    end
                end
                if (last_bit)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rem_next   = rem_reg - 1'b1;
                    walk_next  = {walk_reg[WALK_W-2:0], 1'b0};
                    state_next = S_READ;
                end
            end
            S_DONE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        result_next.node     = icur_reg;
                        result_next.found    = 1'b0;
                        result_next.full_res = full_reg;
                    end
                    OP_LOOKUP:
                    begin
                        result_next.node     = missed_reg ? '0 : lcur_reg;
                        result_next.found    = ~missed_reg;
                        result_next.full_res = 1'b0;
                    end
                    OP_SET:
                    begin
                        result_next.node     = icur_reg;
                        result_next.found    = 1'b0;
                        result_next.full_res = 1'b0;
                    end
                    default:
                    begin
                        result_next.node     = '0;
                        result_next.found    = 1'b0;
                        result_next.full_res = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            op_reg       <= OP_NOP;
            rem_reg      <= '0;
            icur_reg     <= '0;
            lcur_reg     <= '0;
            missed_reg   <= 1'b0;
            free_reg     <= '0;
            full_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            op_reg       <= op_next;
            rem_reg      <= rem_next;
            icur_reg     <= icur_next;
            lcur_reg     <= lcur_next;
            missed_reg   <= missed_next;
            free_reg     <= free_next;
            full_reg     <= full_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg   <= walk_next;
        slot_reg   <= slot_next;
        result_reg <= result_next;
    end

    // single-port trie store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_rd)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/binary_trie_key_walk.sv @@
`default_nettype none

// channel   | handshake           | payload
// ----------+---------------------+-------------------------------------
// item      | start / busy        | cmd, key_byte, key_end, first_of_key,
//           |                     | start_node
// result    | done (strobe)       | node, found, full_res
//
// insert and lookup walk each key bit through S_READ (store read) and S_EVAL (evaluate):
// 8 bits per byte plus the terminator bit on key end, after S_IDLE (dequeue) and before
// S_DONE (result); a skipped bit (lookup after a miss, slot beyond the store) takes only
// S_READ. set-cursor and unused commands go from S_IDLE straight to S_DONE.
// after reset busy stays high while the store is cleared.
// a front register and a two-entry queue take items while the walk runs;
// busy rises when both are full. results cannot be stalled.

module binary_trie_key_walk (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire btk_pkg::item_t    item,
    output logic                   busy,
    output logic                   done,
    output btk_pkg::result_t       result
);
    import btk_pkg::*;

    `include "assert_macros.svh"

    q_stat_t    qstat;
    back_stat_t bstat;
    logic       push;
    logic       pop;
    job_t       push_job;
    job_t       head_job;

    btk_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .qstat    (qstat),
        .bstat    (bstat),
        .busy     (busy),
        .push     (push),
        .push_job (push_job)
    );

    btk_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .qstat    (qstat)
    );

    btk_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_job (head_job),
        .qstat    (qstat),
        .pop      (pop),
        .bstat    (bstat),
        .done     (done),
        .result   (result)
    );

    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `ASSERT_IMPLIES(a_done_idle, clk, rst_n, done, bstat.idle && !bstat.clearing)
    `ASSERT_IMPLIES(a_found_node, clk, rst_n, done && result.found, result.node != '0)
    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, pop, !qstat.empty && bstat.idle)

endmodule

`default_nettype wire
